// ----- rtl/itoa_pkg.sv -----
// Shared constants, command/status structs and the digit-to-character
// function of the integer-to-ASCII converter. No dependencies.
`default_nettype none

package itoa_pkg;

  // Conversion width and its default.
  localparam int VALUE_BITS_DEF = 32;

  // Bits of the working value consumed per division cycle.
  localparam int STEP_BITS = 8;

  // Field widths of the result word.
  localparam int CHAR_W  = 8;
  localparam int LEN_W   = 6;
  localparam int DIGIT_W = 4;

  // Radix register.
  localparam int          RADIX_W     = 5;
  localparam logic [4:0]  RADIX_RESET = 5'd10;
  localparam logic [4:0]  RADIX_MIN   = 5'd2;
  localparam logic [4:0]  RADIX_MAX   = 5'd16;

  // Configuration port.
  localparam int          ADDR_W      = 3;
  localparam int          DATA_W      = 32;
  localparam logic [0:0]  RADIX_WORD  = 1'b0;

  // Character codes.
  localparam logic [7:0] ZERO_CODE   = 8'd48;
  localparam logic [7:0] LETTER_CODE = 8'd55;
  localparam logic [7:0] MINUS_CODE  = 8'd45;
  localparam logic [7:0] TERM_CODE   = 8'd0;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // Take a new input word.
    logic step;        // Run one division cycle.
    logic emit_sign;   // Load the minus sign into the output register.
    logic emit_digit;  // Load the read digit into the output register.
    logic emit_term;   // Load the terminator into the output register.
    logic next_digit;  // Move the read pointer to the next lower digit.
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic conv_done;   // The last digit is being written this cycle.
    logic neg;         // The current value is negative.
    logic idx_zero;    // The read pointer is at the least significant digit.
    logic slot_free;   // The output register can take a word this cycle.
  } sts_t;

  // Map a digit to '0'-'9' or 'A'-'F'.
  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] ext;
    ext = {{(CHAR_W-DIGIT_W){1'b0}}, d};
    if (d < 4'd10) begin
      digit_char = ZERO_CODE + ext;
    end else begin
      digit_char = LETTER_CODE + ext;
    end
  endfunction

endpackage

`default_nettype wire

// ----- rtl/itoa_dp.sv -----
// Datapath of the integer-to-ASCII converter: chunked radix divider,
// digit memory, read pointer and output register. Uses itoa_pkg.
`default_nettype none

module itoa_dp
  import itoa_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire cmd_t                  cmd,
  output      sts_t                  sts,
  input  wire logic [VALUE_BITS-1:0] value,
  input  wire logic [RADIX_W-1:0]    radix,
  input  wire logic                  out_ready,
  output      logic                  out_valid,
  output      logic [CHAR_W-1:0]     out_character,
  output      logic                  out_last,
  output      logic [LEN_W-1:0]      out_length
);

  localparam int CHUNKS  = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
  localparam int PAD_W   = CHUNKS * STEP_BITS;
  localparam int CHUNK_W = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam int CNT_W   = $clog2(VALUE_BITS + 1);
  localparam int IDX_W   = $clog2(VALUE_BITS);

  logic [PAD_W-1:0]   mag_r;
  logic [DIGIT_W-1:0] rem_r;
  logic [RADIX_W-1:0] base_r;
  logic [CHUNK_W-1:0] chunk_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [IDX_W-1:0]   idx_r;
  logic               neg_r;
  logic [DIGIT_W-1:0] rd_r;

  logic [DIGIT_W-1:0] store_m [VALUE_BITS];

  logic               out_valid_r;
  logic [CHAR_W-1:0]  char_r;
  logic               last_r;
  logic [LEN_W-1:0]   len_r;

  logic [PAD_W-1:0]      mag_nxt;
  logic [DIGIT_W-1:0]    rem_nxt;
  logic [RADIX_W-1:0]    base_sat;
  logic [VALUE_BITS-1:0] abs_val;
  logic                  last_chunk;
  logic [CNT_W:0]        len_full;

  // One division cycle: STEP_BITS restoring steps on a 4-bit remainder.
  always_comb begin
    logic [PAD_W-1:0]   w;
    logic [DIGIT_W-1:0] r;
    logic [DIGIT_W:0]   t;
    logic               q;
    w = mag_r;
    r = rem_r;
    for (int k = 0; k < STEP_BITS; k++) begin
      t = {r, w[PAD_W-1]};
      q = (t >= base_r);
      if (q) begin
        r = DIGIT_W'(t - base_r);
      end else begin
        r = t[DIGIT_W-1:0];
      end
      w = {w[PAD_W-2:0], q};
    end
    mag_nxt = w;
    rem_nxt = r;
  end

  always_comb begin
    if (radix < RADIX_MIN) begin
      base_sat = RADIX_MIN;
    end else if (radix > RADIX_MAX) begin
      base_sat = RADIX_MAX;
    end else begin
      base_sat = radix;
    end
  end

  assign abs_val    = value[VALUE_BITS-1] ? (~value + 1'b1) : value;
  assign last_chunk = (chunk_r == CHUNK_W'(CHUNKS - 1));
  assign len_full   = {1'b0, cnt_r} + (CNT_W+1)'(neg_r) + 1'b1;

  assign sts.conv_done = cmd.step && last_chunk &&
                         ((mag_nxt == '0) || (cnt_r == CNT_W'(VALUE_BITS - 1)));
  assign sts.neg       = neg_r;
  assign sts.idx_zero  = (idx_r == '0);
  assign sts.slot_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mag_r   <= '0;
      rem_r   <= '0;
      base_r  <= RADIX_RESET;
      chunk_r <= '0;
      cnt_r   <= '0;
      idx_r   <= '0;
      neg_r   <= 1'b0;
    end else if (cmd.load) begin
      mag_r   <= PAD_W'(abs_val);
      rem_r   <= '0;
      base_r  <= base_sat;
      chunk_r <= '0;
      cnt_r   <= '0;
      neg_r   <= value[VALUE_BITS-1];
    end else if (cmd.step) begin
      mag_r <= mag_nxt;
      if (last_chunk) begin
        rem_r   <= '0;
        chunk_r <= '0;
        cnt_r   <= cnt_r + 1'b1;
        idx_r   <= cnt_r[IDX_W-1:0];
      end else begin
        rem_r   <= rem_nxt;
        chunk_r <= chunk_r + 1'b1;
      end
    end else if (cmd.next_digit) begin
      idx_r <= idx_r - 1'b1;
    end
  end

  // Digit memory: written least significant first, read back in reverse.
  always_ff @(posedge clk) begin
    if (cmd.step && last_chunk) begin
      store_m[cnt_r[IDX_W-1:0]] <= rem_nxt;
    end
    rd_r <= store_m[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_sign || cmd.emit_digit || cmd.emit_term) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_sign) begin
      char_r <= MINUS_CODE;
      last_r <= 1'b0;
      len_r  <= '0;
    end else if (cmd.emit_digit) begin
      char_r <= digit_char(rd_r);
      last_r <= 1'b0;
      len_r  <= '0;
    end else if (cmd.emit_term) begin
      char_r <= TERM_CODE;
      last_r <= 1'b1;
      len_r  <= LEN_W'(len_full);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_character = char_r;
  assign out_last      = last_r;
  assign out_length    = len_r;

endmodule

`default_nettype wire

// ----- rtl/itoa_ctrl.sv -----
// Controller state machine of the integer-to-ASCII converter: sequences
// division, sign, digits and terminator. Uses itoa_pkg.
`default_nettype none

module itoa_ctrl
  import itoa_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output      logic in_ready,
  input  wire sts_t sts,
  output      cmd_t cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_SIGN = 3'd2;
  localparam logic [2:0] ST_RD   = 3'd3;
  localparam logic [2:0] ST_DIG  = 3'd4;
  localparam logic [2:0] ST_TERM = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.step = 1'b1;
        if (sts.conv_done) begin
          state_nxt = ST_SIGN;
        end
      end
      ST_SIGN: begin
        if (!sts.neg) begin
          state_nxt = ST_RD;
        end else if (sts.slot_free) begin
          cmd.emit_sign = 1'b1;
          state_nxt     = ST_RD;
        end
      end
      ST_RD: begin
        state_nxt = ST_DIG;
      end
      ST_DIG: begin
        if (sts.slot_free) begin
          cmd.emit_digit = 1'b1;
          if (sts.idx_zero) begin
            state_nxt = ST_TERM;
          end else begin
            cmd.next_digit = 1'b1;
            state_nxt      = ST_RD;
          end
        end
      end
      ST_TERM: begin
        if (sts.slot_free) begin
          cmd.emit_term = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/integer_to_ascii_radix.sv -----
// Integer-to-ASCII converter, top level: radix register, controller, datapath.
// The divider works through the value in STEP_BITS-bit chunks, one digit per
// pass; each digit is then read and emitted, after a minus sign for a negative
// value, and a terminator word follows. One value is converted at a time.
// Reset (synchronous, active low) idles the controller and restores radix 10.
`default_nettype none

module integer_to_ascii_radix
  import itoa_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,

  // Input channel: one signed value per word.
  input  wire logic                  in_valid,
  output      logic                  in_ready,
  input  wire logic [VALUE_BITS-1:0] in_value,

  // Result channel: one character per word, the terminator marked last.
  output      logic                  out_valid,
  input  wire logic                  out_ready,
  output      logic [CHAR_W-1:0]     out_character,
  output      logic                  out_last,
  output      logic [LEN_W-1:0]      out_length,

  // Configuration port.
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [ADDR_W-1:0]     paddr,
  input  wire logic [DATA_W-1:0]     pwdata,
  output      logic [DATA_W-1:0]     prdata,
  output      logic                  pready
);

  logic [RADIX_W-1:0] radix_r;
  logic               radix_sel;
  cmd_t               cmd;
  sts_t               sts;

  // The radix register sits at word 0; other words read as zero and
  // ignore writes. The port never stalls.
  assign pready    = 1'b1;
  assign radix_sel = (paddr[ADDR_W-1:2] == (ADDR_W-2)'(RADIX_WORD));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= RADIX_RESET;
    end else if (psel && penable && pwrite && radix_sel) begin
      radix_r <= pwdata[RADIX_W-1:0];
    end
  end

  assign prdata = radix_sel ? DATA_W'(radix_r) : '0;

  // The controller runs the divider once per digit, then walks the digit
  // memory from the most significant digit down, one output word at a time.
  // A new value is accepted as soon as the terminator is in the output
  // register, even while that word still waits to be taken.
  itoa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath saturates the radix into two to sixteen when the value is
  // loaded, so a later radix write does not disturb a conversion in flight.
  itoa_dp #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .value         (in_value),
    .radix         (radix_r),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .out_character (out_character),
    .out_last      (out_last),
    .out_length    (out_length)
  );

endmodule

`default_nettype wire

// ----- bench/itoa_checker.sv -----
// Result checker for the integer-to-ASCII converter: tracks the radix register,
// spells every accepted value into its expected characters and compares each word.
// Depends on itoa_pkg for field widths, character codes and the register index.
module itoa_checker
  import itoa_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [31:0]       in_value,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [CHAR_W-1:0] out_character,
  input  logic              out_last,
  input  logic [LEN_W-1:0]  out_length,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output int                pending,
  output int                fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
    logic [LEN_W-1:0]  length;
  } text_word_t;

  text_word_t         expected_text[$];
  logic [RADIX_W-1:0] radix_reg = RADIX_RESET;
  int                 mismatch_total = 0;

  assign fail_count = mismatch_total;

  // Queues the characters that one value turns into under the given radix.
  function automatic void spell_value(input logic [31:0] value, input logic [RADIX_W-1:0] r);
    logic [31:0]        mag;
    logic [31:0]        base;
    logic [DIGIT_W-1:0] digits[32];
    logic [DIGIT_W-1:0] d;
    logic [LEN_W-1:0]   emitted;
    int                 n;
    base = 32'((r < RADIX_MIN) ? RADIX_MIN : (r > RADIX_MAX) ? RADIX_MAX : r);
    mag = value[31] ? (~value + 32'd1) : value;
    n = 0;
    do begin
      digits[n] = DIGIT_W'(mag % base);
      mag = mag / base;
      n++;
    end while (mag != 0 && n < 32);
    emitted = '0;
    if (value[31]) begin
      expected_text.push_back('{MINUS_CODE, 1'b0, '0});
      emitted++;
    end
    for (int i = n - 1; i >= 0; i--) begin
      d = digits[i];
      expected_text.push_back('{(d < 4'd10) ? ZERO_CODE + d : LETTER_CODE + d, 1'b0, '0});
      emitted++;
    end
    expected_text.push_back('{TERM_CODE, 1'b1, emitted + 1'b1});
  endfunction

  always @(posedge clk) begin : watch
    text_word_t want;
    if (!rst_n) begin
      radix_reg = RADIX_RESET;
      expected_text.delete();
      pending <= 0;
    end else begin
      // Only index zero holds a register; writes elsewhere are dropped.
      if (psel && penable && pwrite && pready && (paddr >> 2) == RADIX_WORD) begin
        radix_reg = pwdata[RADIX_W-1:0];
      end
      if (out_valid && out_ready) begin
        if (expected_text.size() == 0) begin
          $error("unexpected word: character %0d last %0d length %0d",
                 out_character, out_last, out_length);
          mismatch_total++;
        end else begin
          want = expected_text.pop_front();
          if (out_character !== want.code) begin
            $error("character mismatch: expected %0d, actual %0d", want.code, out_character);
            mismatch_total++;
          end
          if (out_last !== want.last) begin
            $error("last mismatch: expected %0d, actual %0d", want.last, out_last);
            mismatch_total++;
          end
          if (out_length !== want.length) begin
            $error("length mismatch: expected %0d, actual %0d", want.length, out_length);
            mismatch_total++;
          end
        end
      end
      if (in_valid && in_ready) begin
        spell_value(in_value, radix_reg);
      end
      pending <= expected_text.size();
    end
  end

endmodule

// ----- bench/tb.sv -----
// Top of the integer-to-ASCII converter bench: clock, reset, value and radix stimulus.
// Depends on itoa_pkg, the integer_to_ascii_radix block and the itoa_checker module.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import itoa_pkg::*;

  // The radix register sits at index zero; index one decodes to nothing.
  localparam logic [ADDR_W-1:0] RADIX_ADDR  = {RADIX_WORD, 2'b00};
  localparam logic [ADDR_W-1:0] UNUSED_ADDR = 3'd4;
  localparam int MAX_WAIT      = 4;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS   = 50;
  localparam int DRAIN_LIMIT   = 20000;
  // Quiet cycles after the drain, so that a stray extra word still gets caught.
  localparam int TAIL_CYCLES   = 200;

  logic              clk;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic [31:0]       in_value  = '0;
  logic              out_ready = 1'b0;
  logic              psel      = 1'b0;
  logic              penable   = 1'b0;
  logic              pwrite    = 1'b0;
  logic [ADDR_W-1:0] paddr     = '0;
  logic [DATA_W-1:0] pwdata    = '0;

  wire logic              in_ready;
  wire logic              out_valid;
  wire logic [CHAR_W-1:0] out_character;
  wire logic              out_last;
  wire logic [LEN_W-1:0]  out_length;
  wire logic [DATA_W-1:0] prdata;
  wire logic              pready;

  int          pending;
  int          fail_count;
  int unsigned stall_left = 0;
  // Effective base after saturation, used to aim values at digit-count boundaries.
  int unsigned radix_now  = 10;
  // While quiet is set neither side inserts idle cycles.
  bit          quiet      = 1'b0;

  integer_to_ascii_radix dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_character(out_character),
    .out_last     (out_last),
    .out_length   (out_length),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  itoa_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_character(out_character),
    .out_last     (out_last),
    .out_length   (out_length),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pending      (pending),
    .fail_count   (fail_count)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // The result side stalls for a fresh random number of cycles after every
  // accepted word, so stalls land on signs, digits and terminators alike.
  always @(posedge clk) begin : result_stall
    int unsigned draw;
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && out_ready) begin
      draw = quiet ? 0 : $urandom_range(0, MAX_WAIT);
      out_ready <= (draw == 0);
      stall_left <= draw;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready <= (stall_left == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Offers one value after a random gap and returns at the edge that takes it.
  // Valid is only dropped when a gap follows, so back-to-back words keep it high.
  task automatic send_value(input logic [31:0] v);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Waits until every predicted character has been seen. The first edge lets
  // the checker count a value accepted at the current edge.
  task automatic wait_idle();
    int unsigned waited;
    in_valid <= 1'b0;
    @(posedge clk);
    waited = 0;
    while (pending != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
  endtask

  // Register write with a setup and an access cycle, only once the block is idle.
  task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    logic [RADIX_W-1:0] r;
    wait_idle();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == RADIX_ADDR) begin
      r = data[RADIX_W-1:0];
      radix_now = 32'((r < RADIX_MIN) ? RADIX_MIN : (r > RADIX_MAX) ? RADIX_MAX : r);
    end
  endtask

  // Mix of fully random, small and right-shifted words, powers of the current
  // base and their neighbours (where the digit count changes), zero and the extremes.
  function automatic logic [31:0] pick_value();
    logic [31:0] v;
    longint      p;
    int unsigned k;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom();
      4, 5: v = $urandom_range(0, 400);
      6: begin
        p = 1;
        k = $urandom_range(0, 31);
        repeat (k) begin
          if (p * radix_now <= 64'd2147483648) p = p * radix_now;
        end
        v = 32'(p - $urandom_range(0, 1));
      end
      7: begin
        case ($urandom_range(0, 3))
          0: v = 32'h0000_0000;
          1: v = 32'h7FFF_FFFF;
          2: v = 32'h8000_0000;
          default: v = 32'h8000_0001;
        endcase
      end
      default: v = $urandom() >> $urandom_range(0, 31);
    endcase
    if (!v[31] && $urandom_range(0, 1) == 1) v = -v;
    return v;
  endfunction

  initial begin : stimulus
    int unsigned radix_plan[5];
    radix_plan = '{2, 16, 0, 31, 10};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset radix of ten: zero, one, minus one, both extremes and a ten-digit value.
    send_value(32'h0000_0000);
    send_value(32'h0000_0001);
    send_value(32'hFFFF_FFFF);
    send_value(32'h7FFF_FFFF);
    send_value(32'h8000_0000);
    send_value(32'd1234567890);

    // Hexadecimal brings in the letter digits.
    write_reg(RADIX_ADDR, 32'd16);
    send_value(32'h00AB_CDEF);
    send_value(32'hFFFE_DCBB);
    send_value(32'hFFFF_FFFF);

    // Binary gives the longest runs: the most negative value fills all 34 words.
    write_reg(RADIX_ADDR, 32'd2);
    send_value(32'h8000_0000);
    send_value(32'h7FFF_FFFF);
    send_value(32'h0000_0000);

    // Bases below two saturate to two, bases above sixteen to sixteen.
    write_reg(RADIX_ADDR, 32'd0);
    send_value(32'd5);
    write_reg(RADIX_ADDR, 32'd1);
    send_value(32'hFFFF_FFFA);
    write_reg(RADIX_ADDR, 32'd17);
    send_value(32'd255);
    write_reg(RADIX_ADDR, 32'd31);
    send_value(32'hFFFF_F000);

    // A write to the empty index must leave the radix alone.
    write_reg(UNUSED_ADDR, 32'd3);
    send_value(32'd1000);

    // Only the low five bits of the write data reach the register.
    write_reg(RADIX_ADDR, 32'hFFFF_FFE7);
    send_value(32'd100);
    write_reg(RADIX_ADDR, 32'd3);
    send_value(32'h8000_0000);

    // Random phases: the first few pin the radix extremes, later ones draw the
    // whole five-bit range. Every fourth phase runs with no idling at all.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase < 5) begin
        write_reg(RADIX_ADDR, radix_plan[phase]);
      end else begin
        write_reg(RADIX_ADDR, $urandom());
      end
      quiet = (phase % 4 == 3);
      repeat (PHASE_ITEMS) send_value(pick_value());
    end
    quiet = 1'b0;

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Hang guard, many times the slowest legal run.
  initial begin : watchdog
    #20_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/itoa_pkg.sv
rtl/itoa_dp.sv
rtl/itoa_ctrl.sv
rtl/integer_to_ascii_radix.sv
bench/itoa_checker.sv
bench/tb.sv
